FILE: src/tccw_pkg.sv
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_NL  = 8'd10;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_CR  = 8'd13;

  localparam int unsigned TAB_BLANKS = 4;
  localparam int unsigned VT_ROWS    = 4;
  localparam int unsigned CELL_W     = 16;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } out_item_t;

endpackage

FILE: src/text_console_char_writer.sv
// Top level of the text console character writer.
//
// Usage: input items (cmd, char_code, col, row) arrive on in_valid_i / in_stall_o and
// every item yields exactly one result on out_valid_o / out_stall_i: the cursor after
// the command, its linear offset, and on a read the addressed cell. A transfer happens
// at a clock edge with valid high and stall low. cfg_we_i writes the default attribute.
// The single cell memory port serves one cell per cycle: a printable byte writes
//   one cell, backspace one unless at column 0, tab TAB_BLANKS blanks, vertical tab
//   VT_ROWS*COLUMNS blanks from column 0, clear screen every cell; read cell reads one.
// A result lands in the output register on the edge that ends its item; the next
// item is taken while it waits there.
// Reset clears the cursor to the top left and sets the attribute to 7; the cell
// memory holds garbage until a clear or writes. A stalling receiver holds the output
// register; once the sequencer finishes another item it waits, and in_stall_o stays high.
`timescale 1ns / 1ps
module text_console_char_writer #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tccw_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tccw_pkg::out_item_t  out_data_o
);
  import tccw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic              res_valid;
  logic              res_take;
  out_item_t         res_data;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;
  logic              out_valid_q;
  out_item_t         out_data_q;

  tccw_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_data_o (res_data),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata)
  );

  tccw_cell_ram #(
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/tccw_cell_ram.sv
// Screen cell memory: one port, synchronous write, registered read.
`timescale 1ns / 1ps
module tccw_cell_ram #(
  parameter int unsigned DEPTH = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          addr_i,
  input  logic [tccw_pkg::CELL_W-1:0]       wdata_i,
  output logic [tccw_pkg::CELL_W-1:0]       rdata_o
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tccw_engine.sv
// Command sequencer: cursor, attribute register and cell memory access.
`timescale 1ns / 1ps
module tccw_engine #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [7:0]                                cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  tccw_pkg::in_item_t                        in_data_i,
  output logic                                      res_valid_o,
  input  logic                                      res_take_i,
  output tccw_pkg::out_item_t                       res_data_o,
  output logic                                      ram_we_o,
  output logic                                      ram_re_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]           ram_addr_o,
  output logic [tccw_pkg::CELL_W-1:0]               ram_wdata_o,
  input  logic [tccw_pkg::CELL_W-1:0]               ram_rdata_i
);
  import tccw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(COLUMNS);
  localparam int unsigned YW    = $clog2(ROWS);
  localparam int unsigned VT_N  = VT_ROWS * COLUMNS;
  localparam int unsigned CNTW  = $clog2(VT_N + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_CLEAR,
    S_READ,
    S_RDDATA,
    S_RESP
  } state_e;

  state_e          state_q, state_d;
  logic [XW-1:0]   x_q, x_d;
  logic [YW-1:0]   y_q, y_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [XW-1:0]   rcol_q, rcol_d;
  logic [YW-1:0]   rrow_q, rrow_d;
  logic [7:0]      rchar_q, rchar_d;
  logic [7:0]      rattr_q, rattr_d;
  logic [7:0]      attr_q;

  logic [XW-1:0]   ax;
  logic [YW-1:0]   ay;
  logic [AW-1:0]   mul_addr;
  logic            use_clr;
  logic            adv;
  logic            x_last;
  logic [YW-1:0]   y_next;
  logic            col_ok;
  logic            row_ok;

  assign x_last = (x_q == XW'(COLUMNS - 1));
  assign y_next = (y_q == YW'(ROWS - 1)) ? '0 : y_q + 1'b1;
  assign col_ok = (9'(in_data_i.col) < 9'(COLUMNS));
  assign row_ok = (8'(in_data_i.row) < 8'(ROWS));

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    rcol_d      = rcol_q;
    rrow_d      = rrow_q;
    rchar_d     = rchar_q;
    rattr_d     = rattr_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_wdata_o = {attr_q, 8'h00};
    ax          = x_q;
    ay          = y_q;
    use_clr     = 1'b0;
    adv         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rchar_d = '0;
          rattr_d = '0;
          state_d = S_RESP;
          case (in_data_i.cmd)
            CMD_PUT: begin
              case (in_data_i.char_code)
                CODE_NL: begin
                  x_d = '0;
                  y_d = y_next;
                end
                CODE_CR: x_d = '0;
                CODE_TAB: begin
                  cnt_d   = CNTW'(TAB_BLANKS);
                  state_d = S_EMIT;
                end
                CODE_BS: begin
                  if (x_q != '0) begin
                    ax       = x_q - 1'b1;
                    x_d      = x_q - 1'b1;
                    ram_we_o = 1'b1;
                  end
                end
                CODE_VT: begin
                  x_d     = '0;
                  cnt_d   = CNTW'(VT_N);
                  state_d = S_EMIT;
                end
                default: begin
                  ram_we_o    = 1'b1;
                  ram_wdata_o = {attr_q, in_data_i.char_code};
                  adv         = 1'b1;
                end
              endcase
            end
            CMD_CLEAR: begin
              clr_d   = '0;
              x_d     = '0;
              y_d     = '0;
              state_d = S_CLEAR;
            end
            CMD_SET: begin
              x_d = col_ok ? XW'(in_data_i.col) : XW'(COLUMNS - 1);
              y_d = row_ok ? YW'(in_data_i.row) : YW'(ROWS - 1);
            end
            CMD_READ: begin
              rcol_d = XW'(in_data_i.col);
              rrow_d = YW'(in_data_i.row);
              if (col_ok && row_ok) begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        ram_we_o = 1'b1;
        adv      = 1'b1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          state_d = S_RESP;
        end
      end
      S_CLEAR: begin
        use_clr  = 1'b1;
        ram_we_o = 1'b1;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        ax       = rcol_q;
        ay       = rrow_q;
        ram_re_o = 1'b1;
        state_d  = S_RDDATA;
      end
      S_RDDATA: begin
        rchar_d = ram_rdata_i[7:0];
        rattr_d = ram_rdata_i[15:8];
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (x_last) begin
        x_d = '0;
        y_d = y_next;
      end else begin
        x_d = x_q + 1'b1;
      end
    end
  end

  assign mul_addr   = AW'(ay) * AW'(COLUMNS) + AW'(ax);
  assign ram_addr_o = use_clr ? clr_q : mul_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  always_comb begin
    res_data_o.cursor_col    = 7'(x_q);
    res_data_o.cursor_row    = 5'(y_q);
    res_data_o.cursor_offset = 11'(mul_addr);
    res_data_o.read_char     = rchar_q;
    res_data_o.read_attr     = rattr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
      rcol_q  <= '0;
      rrow_q  <= '0;
      rchar_q <= '0;
      rattr_q <= '0;
      attr_q  <= ATTR_RESET;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      rcol_q  <= rcol_d;
      rrow_q  <= rrow_d;
      rchar_q <= rchar_d;
      rattr_q <= rattr_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_q < XW'(COLUMNS - 1)) || (x_q == XW'(COLUMNS - 1)))
    else $error("cursor column out of range");

  a_we_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (ram_addr_o < AW'(CELLS - 1)) || (ram_addr_o == AW'(CELLS - 1)))
    else $error("cell write outside screen");

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("cell read and write in one cycle");

  a_read_data_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> (state_q == S_RDDATA))
    else $error("read data not captured after read");

  a_resp_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_take_i) |=> !res_valid_o && !in_stall_o)
    else $error("result transfer did not release the sequencer");

endmodule
